@@ rtl/amfc_pkg.sv @@
// ----------------------------------------------------------------------------
// amfc_pkg: shared types and constants for the MPPT freeze controller
// Field widths, register map, configuration and state records.
// ----------------------------------------------------------------------------
package amfc_pkg;

   // field widths
   localparam int VOLT_W   = 16;
   localparam int POWER_W  = 20;
   localparam int IRR_W    = 11;
   localparam int COUNT_W  = 8;
   localparam int DECAY_W  = 2;
   localparam int TIMER_W  = 16;

   // stream payload widths (whole bytes)
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;

   // register indexes (byte address = 4 * index)
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SIZE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IRR_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANGE_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FREEZE_TICKS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_VOLTAGE  = 3'd4;

   // register reset values
   localparam logic [VOLT_W-1:0]  RST_STEP_SIZE     = 16'd100;
   localparam logic [IRR_W-1:0]   RST_IRR_THRESHOLD = 11'd100;
   localparam logic [COUNT_W-1:0] RST_CHANGE_LIMIT  = 8'd3;
   localparam logic [TIMER_W-1:0] RST_FREEZE_TICKS  = 16'd60;
   localparam logic [VOLT_W-1:0]  RST_HOLD_VOLTAGE  = 16'd19500;

   // decay divides stable ticks by this period
   localparam logic [DECAY_W-1:0] DECAY_PERIOD = 2'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;

   // output mode codes
   localparam logic MODE_TRACK  = 1'b0;
   localparam logic MODE_FROZEN = 1'b1;

   typedef struct packed {
      logic [VOLT_W-1:0]  step_size;
      logic [IRR_W-1:0]   irradiance_threshold;
      logic [COUNT_W-1:0] change_limit;
      logic [TIMER_W-1:0] freeze_ticks;
      logic [VOLT_W-1:0]  hold_voltage;
   } cfg_type;

   typedef struct packed {
      logic [IRR_W-1:0]   prev_irradiance;
      logic [COUNT_W-1:0] change_count;
      logic [DECAY_W-1:0] decay_count;
      logic [TIMER_W-1:0] freeze_timer;
      logic [VOLT_W-1:0]  prev_voltage;
      logic [POWER_W-1:0] prev_power;
   } state_type;

   typedef struct packed {
      logic [IRR_W-1:0]   irradiance;
      logic [POWER_W-1:0] measured_power;
      logic [VOLT_W-1:0]  measured_voltage;
   } item_type;

   typedef struct packed {
      logic               mode;
      logic [VOLT_W-1:0]  voltage_reference;
   } result_type;

endpackage

@@ rtl/amfc_step.sv @@
// ----------------------------------------------------------------------------
// amfc_step: per-tick update of the freeze controller
// Combinational next state and result for one measurement tick.
// ----------------------------------------------------------------------------
module amfc_step
   import amfc_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state_cur,
   input  item_type   item,
   output state_type  state_nxt,
   output result_type result
);

   logic [IRR_W-1:0]   irr_diff;
   logic               abrupt;
   logic [DECAY_W-1:0] decay_inc;
   logic [COUNT_W-1:0] count_upd;
   logic [DECAY_W-1:0] decay_upd;
   logic               power_up;
   logic               volt_up;
   logic [VOLT_W:0]    volt_sum;
   logic [VOLT_W-1:0]  volt_inc;
   logic [VOLT_W-1:0]  volt_dec;
   logic [VOLT_W-1:0]  volt_track;

   // irradiance change against the previous tick
   assign irr_diff = (item.irradiance >= state_cur.prev_irradiance) ?
                     item.irradiance - state_cur.prev_irradiance :
                     state_cur.prev_irradiance - item.irradiance;
   assign abrupt   = irr_diff >= cfg.irradiance_threshold;
   assign decay_inc = state_cur.decay_count + 2'd1;

   // change count: saturating increment, slow decay on stable ticks
   always_comb begin
      count_upd = state_cur.change_count;
      decay_upd = state_cur.decay_count;
      if (abrupt) begin
         if (state_cur.change_count != COUNT_MAX) begin
            count_upd = state_cur.change_count + 8'd1;
         end
      end else if (state_cur.change_count != '0) begin
         if (decay_inc >= DECAY_PERIOD) begin
            count_upd = state_cur.change_count - 8'd1;
            decay_upd = '0;
         end else begin
            decay_upd = decay_inc;
         end
      end
   end

   // perturb and observe with saturation
   assign power_up = item.measured_power > state_cur.prev_power;
   assign volt_up  = item.measured_voltage > state_cur.prev_voltage;
   assign volt_sum = {1'b0, item.measured_voltage} + {1'b0, cfg.step_size};
   assign volt_inc = volt_sum[VOLT_W] ? '1 : volt_sum[VOLT_W-1:0];
   assign volt_dec = (item.measured_voltage > cfg.step_size) ?
                     item.measured_voltage - cfg.step_size : '0;
   assign volt_track = (power_up == volt_up) ? volt_inc : volt_dec;

   // tick outcome: frozen, freeze start or tracking
   always_comb begin
      state_nxt = state_cur;
      result.voltage_reference = cfg.hold_voltage;
      result.mode = MODE_FROZEN;
      state_nxt.prev_irradiance = item.irradiance;
      if (state_cur.freeze_timer != '0) begin
         state_nxt.freeze_timer = state_cur.freeze_timer - 16'd1;
         state_nxt.change_count = '0;
      end else begin
         state_nxt.decay_count = decay_upd;
         if (count_upd >= cfg.change_limit) begin
            state_nxt.freeze_timer = (cfg.freeze_ticks != '0) ?
                                     cfg.freeze_ticks - 16'd1 : '0;
            state_nxt.change_count = '0;
         end else begin
            state_nxt.change_count = count_upd;
            state_nxt.prev_voltage = item.measured_voltage;
            state_nxt.prev_power   = item.measured_power;
            result.voltage_reference = volt_track;
            result.mode = MODE_TRACK;
         end
      end
   end

endmodule

@@ rtl/adaptive_mppt_freeze_controller_unit.sv @@
// ----------------------------------------------------------------------------
// adaptive_mppt_freeze_controller_unit: P&O MPPT with irradiance freeze
// Input register, combinational update stage, output register; APB-style CSRs.
// ----------------------------------------------------------------------------
// One measurement transaction in gives one setpoint transaction out. The block
// takes a transaction every cycle whenever the result side takes data: a
// transaction is held in the input register, is evaluated by the update stage
// against the tracker state, and the result is then captured in the output
// register. The tracker state is updated in the same cycle a result is
// produced, which is what limits the rate to one transaction per clock.
// rsp_tuser carries mode: 0 for normal tracking, 1 while frozen at
// hold_voltage.
// Configuration registers sit at byte addresses 0 (step_size), 4
// (irradiance_threshold), 8 (change_limit), 12 (freeze_ticks) and 16
// (hold_voltage); write them only while no transaction is in flight.
module adaptive_mppt_freeze_controller_unit
   import amfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // measurements
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [15:0] measured_voltage, [35:16] measured_power, [46:36] irradiance
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // setpoints
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] voltage_reference
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] mode
   output logic                  rsp_tuser,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type           cfg_ff, cfg_in;
   state_type         state_ff, state_nxt;
   item_type          item_ff;
   logic              item_valid_ff;
   result_type        result_ff, result_nxt;
   logic              rsp_valid_ff;
   logic              advance;
   logic              csr_write;
   logic [CSR_IDX_W-1:0] csr_index;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_STEP_SIZE:     cfg_in.step_size            = csr_pwdata[VOLT_W-1:0];
            REG_IRR_THRESHOLD: cfg_in.irradiance_threshold = csr_pwdata[IRR_W-1:0];
            REG_CHANGE_LIMIT:  cfg_in.change_limit         = csr_pwdata[COUNT_W-1:0];
            REG_FREEZE_TICKS:  cfg_in.freeze_ticks         = csr_pwdata[TIMER_W-1:0];
            REG_HOLD_VOLTAGE:  cfg_in.hold_voltage         = csr_pwdata[VOLT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size            <= RST_STEP_SIZE;
         cfg_ff.irradiance_threshold <= RST_IRR_THRESHOLD;
         cfg_ff.change_limit         <= RST_CHANGE_LIMIT;
         cfg_ff.freeze_ticks         <= RST_FREEZE_TICKS;
         cfg_ff.hold_voltage         <= RST_HOLD_VOLTAGE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register readback
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_STEP_SIZE:     csr_prdata = {16'd0, cfg_ff.step_size};
         REG_IRR_THRESHOLD: csr_prdata = {21'd0, cfg_ff.irradiance_threshold};
         REG_CHANGE_LIMIT:  csr_prdata = {24'd0, cfg_ff.change_limit};
         REG_FREEZE_TICKS:  csr_prdata = {16'd0, cfg_ff.freeze_ticks};
         REG_HOLD_VOLTAGE:  csr_prdata = {16'd0, cfg_ff.hold_voltage};
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- datapath handshake ----------------
   // the update stage fires when the output register is free or drains
   assign advance    = item_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~item_valid_ff | advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         item_ff.measured_voltage <= req_tdata[15:0];
         item_ff.measured_power   <= req_tdata[35:16];
         item_ff.irradiance       <= req_tdata[46:36];
      end
   end

   // per-tick update
   amfc_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_nxt),
      .result    (result_nxt)
   );

   // tracker state, committed when a transaction moves to the output
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_nxt;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_nxt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = result_ff.voltage_reference;
   assign rsp_tuser  = result_ff.mode;

endmodule
